@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the dispatcher modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define TPJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define TPJD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/tpjd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpjd_pkg
// shared types, constants and pointer helpers of the job dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpjd_pkg;

  localparam int NUM_WORKERS = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_OUT     = 8;

  localparam int WW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(MAX_OUT + 1);

  typedef logic [PW-1:0]          ptr_t;
  typedef logic [CW-1:0]          cnt_t;
  typedef logic [CW:0]            acc_t;
  typedef logic [WW-1:0]          widx_t;
  typedef logic [NUM_WORKERS-1:0] busy_t;
  typedef logic [NW-1:0]          nout_t;

  typedef struct packed {
    logic [15:0] qid;
    logic [31:0] hnd;
  } entry_t;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_DONE   = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_UPD_LOW  = 2'd0,
    REG_UPD_HIGH = 2'd1,
    REG_SLOW_A   = 2'd2,
    REG_SLOW_B   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MERGE,
    ST_MWRITE,
    ST_DECIDE,
    ST_FETCH,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic merge_rd;
    logic merge_wr;
    logic fetch;
    logic emit_job;
    logic emit_empty;
  } ctrl_cmd_t;

  typedef struct packed {
    logic merge_pend;
    logic go;
    logic first;
    logic last;
  } dp_status_t;

  function automatic ptr_t ptr_add(ptr_t p, cnt_t k);
    acc_t s;
    s = acc_t'(p) + acc_t'(k);
    if (s >= acc_t'(QUEUE_DEPTH)) begin
      s = s - acc_t'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  function automatic ptr_t ptr_sub(ptr_t p, cnt_t k);
    acc_t s;
    if (acc_t'(p) >= acc_t'(k)) begin
      s = acc_t'(p) - acc_t'(k);
    end else begin
      s = acc_t'(p) + acc_t'(QUEUE_DEPTH) - acc_t'(k);
    end
    return s[PW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/tpjd_if.sv @@
// ----------------------------------------------------------------------------
// tpjd_if
// request, result and register write channels of the job dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpjd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] type_id;
  logic [31:0] job_handle;
  logic [2:0]  worker_index;
  modport source (output valid, opcode, type_id, job_handle, worker_index, input ready);
  modport sink (input valid, opcode, type_id, job_handle, worker_index, output ready);
endinterface

interface tpjd_rsp_if;
  logic        valid;
  logic        ready;
  logic        dispatched;
  logic [2:0]  target_worker;
  logic [15:0] job_type_id;
  logic [31:0] job_reference;
  logic        dropped;
  logic        phase_is_update;
  logic        last;
  modport source (output valid, dispatched, target_worker, job_type_id, job_reference,
                  dropped, phase_is_update, last, input ready);
  modport sink (input valid, dispatched, target_worker, job_type_id, job_reference,
                dropped, phase_is_update, last, output ready);
endinterface

interface tpjd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/tpjd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpjd_ctrl
// sequencer of the dispatcher: request intake, slow merge, dispatch loop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpjd_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  input  wire tpjd_pkg::dp_status_t status_i,
  output tpjd_pkg::ctrl_cmd_t       cmd_o
);

  tpjd_pkg::state_e st_q, st_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      tpjd_pkg::ST_IDLE: begin
        if (in_valid_i) st_d = tpjd_pkg::ST_EXEC;
      end
      tpjd_pkg::ST_EXEC: st_d = tpjd_pkg::ST_MERGE;
      tpjd_pkg::ST_MERGE: begin
        st_d = status_i.merge_pend ? tpjd_pkg::ST_MWRITE : tpjd_pkg::ST_DECIDE;
      end
      tpjd_pkg::ST_MWRITE: st_d = tpjd_pkg::ST_MERGE;
      tpjd_pkg::ST_DECIDE: begin
        if (status_i.go) st_d = tpjd_pkg::ST_FETCH;
        else if (status_i.first) st_d = tpjd_pkg::ST_EMPTY;
        else st_d = tpjd_pkg::ST_IDLE;
      end
      tpjd_pkg::ST_FETCH: st_d = tpjd_pkg::ST_EMIT;
      tpjd_pkg::ST_EMIT: begin
        if (slot_free) st_d = status_i.last ? tpjd_pkg::ST_IDLE : tpjd_pkg::ST_DECIDE;
      end
      tpjd_pkg::ST_EMPTY: begin
        if (slot_free) st_d = tpjd_pkg::ST_IDLE;
      end
      default: st_d = tpjd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      tpjd_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      tpjd_pkg::ST_EXEC:   cmd_o.exec = 1'b1;
      tpjd_pkg::ST_MERGE:  cmd_o.merge_rd = status_i.merge_pend;
      tpjd_pkg::ST_MWRITE: cmd_o.merge_wr = 1'b1;
      tpjd_pkg::ST_DECIDE: ;
      tpjd_pkg::ST_FETCH:  cmd_o.fetch = 1'b1;
      tpjd_pkg::ST_EMIT:   cmd_o.emit_job = slot_free;
      tpjd_pkg::ST_EMPTY:  cmd_o.emit_empty = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit_job || cmd_o.emit_empty) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tpjd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TPJD_ASSERT(a_emit_after_fetch, st_q == tpjd_pkg::ST_EMIT |-> $past(st_q) == tpjd_pkg::ST_FETCH || $past(st_q) == tpjd_pkg::ST_EMIT, "result stage entered without a fetch")
  `TPJD_ASSERT(a_mwrite_after_merge, st_q == tpjd_pkg::ST_MWRITE |-> $past(st_q) == tpjd_pkg::ST_MERGE, "merge write without a merge read")
  `TPJD_ASSERT_NEVER(a_load_over_full, out_valid_q && !out_ready_i && (cmd_o.emit_job || cmd_o.emit_empty), "result register overwritten")

endmodule

`default_nettype wire

@@ hdl/tpjd_dp.sv @@
// ----------------------------------------------------------------------------
// tpjd_dp
// datapath: queue memories, ring pointers, worker busy bits, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpjd_dp (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire tpjd_pkg::ctrl_cmd_t  cmd_i,
  output tpjd_pkg::dp_status_t      status_o,
  input  wire  [1:0]                opcode_i,
  input  wire  [15:0]               type_id_i,
  input  wire  [31:0]               job_handle_i,
  input  wire  [2:0]                worker_index_i,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire  [1:0]                cfg_index_i,
  input  wire  [15:0]               cfg_data_i,
  output logic                      dispatched_o,
  output logic [2:0]                target_worker_o,
  output logic [15:0]               job_type_id_o,
  output logic [31:0]               job_reference_o,
  output logic                      dropped_o,
  output logic                      phase_is_update_o,
  output logic                      last_o
);

  // queue memories
  tpjd_pkg::entry_t u_mem [tpjd_pkg::QUEUE_DEPTH];
  tpjd_pkg::entry_t s_mem [tpjd_pkg::QUEUE_DEPTH];
  tpjd_pkg::entry_t q_mem [tpjd_pkg::QUEUE_DEPTH];
  tpjd_pkg::entry_t u_rd_q, s_rd_q, q_rd_q;

  logic [15:0] upd_low_q, upd_high_q, slow_a_q, slow_b_q;

  tpjd_pkg::opcode_e op_q, op_d;
  logic [15:0]       qid_q, qid_d;
  logic [31:0]       hnd_q, hnd_d;
  logic [2:0]        widx_q, widx_d;
  logic              drop_q, drop_d;
  logic              phase_q, phase_d;
  tpjd_pkg::busy_t   busy_q, busy_d;
  tpjd_pkg::ptr_t    u_head_q, u_head_d, s_head_q, s_head_d, q_head_q, q_head_d;
  tpjd_pkg::cnt_t    u_cnt_q, u_cnt_d, s_cnt_q, s_cnt_d, q_cnt_q, q_cnt_d;
  tpjd_pkg::cnt_t    m_q, m_d;
  tpjd_pkg::ptr_t    sr_q, sr_d, qw_q, qw_d;
  tpjd_pkg::nout_t   n_q, n_d;

  logic              disp_q, disp_d, odrop_q, odrop_d, ophase_q, ophase_d, olast_q, olast_d;
  tpjd_pkg::widx_t   ow_q, ow_d;
  tpjd_pkg::entry_t  oent_q, oent_d;

  logic              u_we, s_we, q_we;
  tpjd_pkg::ptr_t    u_waddr, s_waddr, q_waddr;
  tpjd_pkg::entry_t  wdata, q_wdata;

  logic              free_found, free_after, widx_ok, is_upd, is_slow, phase_new, has_work;
  tpjd_pkg::widx_t   free_idx, sel_w;
  tpjd_pkg::cnt_t    act_cnt, space, k;
  tpjd_pkg::ptr_t    qh_new;
  tpjd_pkg::busy_t   busy_sel;
  tpjd_pkg::entry_t  act_rd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tpjd_pkg::NUM_WORKERS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = tpjd_pkg::widx_t'(i);
      end
    end
  end

  assign widx_ok    = 32'(widx_q) < 32'(tpjd_pkg::NUM_WORKERS);
  assign sel_w      = (op_q == tpjd_pkg::OP_DONE) ? tpjd_pkg::widx_t'(widx_q) : free_idx;
  assign busy_sel   = tpjd_pkg::busy_t'(1) << sel_w;
  assign free_after = ~&(busy_q | busy_sel);
  assign act_cnt    = phase_q ? u_cnt_q : q_cnt_q;
  assign act_rd     = phase_q ? u_rd_q : q_rd_q;
  assign is_upd     = (qid_q >= upd_low_q) && (qid_q <= upd_high_q);
  assign is_slow    = (qid_q == slow_a_q) || (qid_q == slow_b_q);
  assign has_work   = phase_q ? ((s_cnt_q != '0) || (q_cnt_q != '0)) : (u_cnt_q != '0);
  assign phase_new  = has_work ? !phase_q : phase_q;
  assign space      = tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH) - q_cnt_q;
  assign k          = (s_cnt_q < space) ? s_cnt_q : space;
  assign qh_new     = tpjd_pkg::ptr_sub(q_head_q, k);
  assign wdata      = '{qid: qid_q, hnd: hnd_q};

  always_comb begin
    status_o.merge_pend = (m_q != '0);
    status_o.first      = (n_q == '0);
    case (op_q)
      tpjd_pkg::OP_SUBMIT: status_o.go = free_found && (act_cnt != '0);
      tpjd_pkg::OP_DONE:   status_o.go = widx_ok && (act_cnt != '0);
      tpjd_pkg::OP_TICK: begin
        status_o.go = (32'(n_q) < 32'(tpjd_pkg::MAX_OUT)) && (act_cnt != '0) && free_found;
      end
      default: status_o.go = 1'b0;
    endcase
    if (op_q == tpjd_pkg::OP_TICK) begin
      status_o.last = !((32'(n_q) + 32'd1 < 32'(tpjd_pkg::MAX_OUT)) &&
                        (act_cnt > tpjd_pkg::cnt_t'(1)) && free_after);
    end else begin
      status_o.last = 1'b1;
    end
  end

  always_comb begin
    op_d = op_q; qid_d = qid_q; hnd_d = hnd_q; widx_d = widx_q; drop_d = drop_q;
    phase_d = phase_q; busy_d = busy_q;
    u_head_d = u_head_q; s_head_d = s_head_q; q_head_d = q_head_q;
    u_cnt_d = u_cnt_q; s_cnt_d = s_cnt_q; q_cnt_d = q_cnt_q;
    m_d = m_q; sr_d = sr_q; qw_d = qw_q; n_d = n_q;
    disp_d = disp_q; odrop_d = odrop_q; ophase_d = ophase_q; olast_d = olast_q;
    ow_d = ow_q; oent_d = oent_q;
    u_we = 1'b0; s_we = 1'b0; q_we = 1'b0;
    u_waddr = tpjd_pkg::ptr_add(u_head_q, u_cnt_q);
    s_waddr = tpjd_pkg::ptr_add(s_head_q, s_cnt_q);
    q_waddr = tpjd_pkg::ptr_add(q_head_q, q_cnt_q);
    q_wdata = wdata;

    if (cmd_i.latch) begin
      op_d   = tpjd_pkg::opcode_e'(opcode_i);
      qid_d  = type_id_i;
      hnd_d  = job_handle_i;
      widx_d = worker_index_i;
      drop_d = 1'b0;
      n_d    = '0;
      m_d    = '0;
    end

    if (cmd_i.exec) begin
      case (op_q)
        tpjd_pkg::OP_SUBMIT: begin
          if (is_upd) begin
            if (u_cnt_q < tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH)) begin
              u_we    = 1'b1;
              u_cnt_d = u_cnt_q + tpjd_pkg::cnt_t'(1);
            end else drop_d = 1'b1;
          end else if (is_slow) begin
            if (s_cnt_q < tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH)) begin
              s_we    = 1'b1;
              s_cnt_d = s_cnt_q + tpjd_pkg::cnt_t'(1);
            end else drop_d = 1'b1;
          end else begin
            if (q_cnt_q < tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH)) begin
              q_we    = 1'b1;
              q_cnt_d = q_cnt_q + tpjd_pkg::cnt_t'(1);
            end else drop_d = 1'b1;
          end
        end
        tpjd_pkg::OP_DONE: begin
          if (widx_ok) busy_d = busy_q & ~busy_sel;
        end
        tpjd_pkg::OP_TICK: begin
          phase_d = phase_new;
          if (!phase_new) begin
            q_head_d = qh_new;
            q_cnt_d  = q_cnt_q + k;
            qw_d     = qh_new;
            sr_d     = s_head_q;
            s_head_d = tpjd_pkg::ptr_add(s_head_q, k);
            s_cnt_d  = s_cnt_q - k;
            m_d      = k;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.merge_wr) begin
      q_we    = 1'b1;
      q_waddr = qw_q;
      q_wdata = s_rd_q;
      qw_d    = tpjd_pkg::ptr_add(qw_q, tpjd_pkg::cnt_t'(1));
      sr_d    = tpjd_pkg::ptr_add(sr_q, tpjd_pkg::cnt_t'(1));
      m_d     = m_q - tpjd_pkg::cnt_t'(1);
    end

    if (cmd_i.emit_job) begin
      if (phase_q) begin
        u_head_d = tpjd_pkg::ptr_add(u_head_q, tpjd_pkg::cnt_t'(1));
        u_cnt_d  = u_cnt_q - tpjd_pkg::cnt_t'(1);
      end else begin
        q_head_d = tpjd_pkg::ptr_add(q_head_q, tpjd_pkg::cnt_t'(1));
        q_cnt_d  = q_cnt_q - tpjd_pkg::cnt_t'(1);
      end
      busy_d   = busy_q | busy_sel;
      n_d      = n_q + tpjd_pkg::nout_t'(1);
      disp_d   = 1'b1;
      ow_d     = sel_w;
      oent_d   = act_rd;
      odrop_d  = drop_q;
      ophase_d = phase_q;
      olast_d  = status_o.last;
    end

    if (cmd_i.emit_empty) begin
      disp_d   = 1'b0;
      ow_d     = '0;
      oent_d   = '0;
      odrop_d  = drop_q;
      ophase_d = phase_q;
      olast_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[u_waddr] <= wdata;
    if (s_we) s_mem[s_waddr] <= wdata;
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (cmd_i.merge_rd) s_rd_q <= s_mem[sr_q];
    if (cmd_i.fetch) begin
      u_rd_q <= u_mem[u_head_q];
      q_rd_q <= q_mem[q_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q     <= op_d;
      qid_q    <= qid_d;
      hnd_q    <= hnd_d;
      widx_q   <= widx_d;
      drop_q   <= drop_d;
      sr_q     <= sr_d;
      qw_q     <= qw_d;
      ow_q     <= ow_d;
      oent_q   <= oent_d;
      disp_q   <= disp_d;
      odrop_q  <= odrop_d;
      ophase_q <= ophase_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_low_q  <= 16'd1001;
      upd_high_q <= 16'd1008;
      slow_a_q   <= 16'd9;
      slow_b_q   <= 16'd6;
      phase_q    <= 1'b0;
      busy_q     <= '0;
      u_head_q   <= '0;
      s_head_q   <= '0;
      q_head_q   <= '0;
      u_cnt_q    <= '0;
      s_cnt_q    <= '0;
      q_cnt_q    <= '0;
      m_q        <= '0;
      n_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (tpjd_pkg::cfg_idx_e'(cfg_index_i))
          tpjd_pkg::REG_UPD_LOW:  upd_low_q  <= cfg_data_i;
          tpjd_pkg::REG_UPD_HIGH: upd_high_q <= cfg_data_i;
          tpjd_pkg::REG_SLOW_A:   slow_a_q   <= cfg_data_i;
          tpjd_pkg::REG_SLOW_B:   slow_b_q   <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      busy_q   <= busy_d;
      u_head_q <= u_head_d;
      s_head_q <= s_head_d;
      q_head_q <= q_head_d;
      u_cnt_q  <= u_cnt_d;
      s_cnt_q  <= s_cnt_d;
      q_cnt_q  <= q_cnt_d;
      m_q      <= m_d;
      n_q      <= n_d;
    end
  end

  assign dispatched_o      = disp_q;
  assign target_worker_o   = 3'(ow_q);
  assign job_type_id_o     = oent_q.qid;
  assign job_reference_o   = oent_q.hnd;
  assign dropped_o         = odrop_q;
  assign phase_is_update_o = ophase_q;
  assign last_o            = olast_q;

  `TPJD_ASSERT(a_counts_bounded, 1'b1 |-> u_cnt_q <= tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH) && s_cnt_q <= tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH) && q_cnt_q <= tpjd_pkg::cnt_t'(tpjd_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `TPJD_ASSERT_NEVER(a_busy_target, cmd_i.emit_job && ((busy_q & busy_sel) != '0), "job given to a busy worker")
  `TPJD_ASSERT_NEVER(a_pop_empty, cmd_i.emit_job && act_cnt == '0, "pop from an empty queue")

endmodule

`default_nettype wire

@@ hdl/two_phase_job_dispatcher.sv @@
// ----------------------------------------------------------------------------
// two_phase_job_dispatcher
// sorts submitted jobs into update, slow and query queues and hands them to
// a pool of workers in alternating update and query phases
// ----------------------------------------------------------------------------
// One request is worked on at a time. A submit, done or unused opcode passes
// through intake, queue update, merge check, dispatch decision, queue memory
// read and result load when a job is dispatched, and skips the queue memory
// read when nothing is dispatched. A tick may also merge M slow jobs onto the
// front of the query queue (one read and one write of the queue memories per
// job) and gives 1 to 8 results, each with its own dispatch decision, queue
// memory read and result load, or one empty result when it dispatches nothing.
// A result that finds the output register still full waits until it is freed.
// A result waits in the output register while the next request is taken in.
// Queue memories need no clearing after reset. The user writes registers over
// the cfg channel only while the block is idle; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none

module two_phase_job_dispatcher (
  input wire          clk_i,
  input wire          rst_ni,
  tpjd_req_if.sink    req_i,
  tpjd_rsp_if.source  rsp_o,
  tpjd_cfg_if.sink    cfg_i
);

  tpjd_pkg::ctrl_cmd_t  cmd;
  tpjd_pkg::dp_status_t status;

  tpjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpjd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .opcode_i          (req_i.opcode),
    .type_id_i         (req_i.type_id),
    .job_handle_i      (req_i.job_handle),
    .worker_index_i    (req_i.worker_index),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_ready_o       (cfg_i.ready),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .dispatched_o      (rsp_o.dispatched),
    .target_worker_o   (rsp_o.target_worker),
    .job_type_id_o     (rsp_o.job_type_id),
    .job_reference_o   (rsp_o.job_reference),
    .dropped_o         (rsp_o.dropped),
    .phase_is_update_o (rsp_o.phase_is_update),
    .last_o            (rsp_o.last)
  );

endmodule

`default_nettype wire
